// ===== rtl/core/nfa_pkg.sv =====
// ----------------------------------------------------------------------------
// nfa_pkg
// shared command and status codes of the next-fit identifier allocator
// ----------------------------------------------------------------------------
package nfa_pkg;

  // command field
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  // result status field
  typedef enum logic [2:0] {
    STATUS_OK           = 3'd0,
    STATUS_FULL         = 3'd1,
    STATUS_TAKEN        = 3'd2,
    STATUS_INVALID      = 3'd3,
    STATUS_ALREADY_FREE = 3'd4
  } status_e;

  // identifier table size, the field widths below are sized for it
  localparam int unsigned NumIds      = 64;

  localparam int unsigned IdentWidth  = 7;
  localparam int unsigned GrantWidth  = 6;
  localparam int unsigned CountWidth  = 7;
  localparam int unsigned StatusWidth = 3;

endpackage

// ===== rtl/core/nfa_used_ram.sv =====
// ----------------------------------------------------------------------------
// nfa_used_ram
// used-bit store, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
module nfa_used_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic             wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic             rdata_o
);

  logic mem [Depth];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/next_fit_id_allocator_core.sv =====
// ----------------------------------------------------------------------------
// next_fit_id_allocator_core
// identifier allocator: used-bit memory, in-use count and next-fit search
// ----------------------------------------------------------------------------
//
// channel   direction  transfer                    payload
// command   in         start && !busy at clk edge  cmd_i, ident_i
// result    out        done_o high for one cycle   status_o, granted_id_o,
//                                                  in_use_count_o
//
// sequence: full table or invalid free is answered from idle with no memory read;
//   a named allocate or a free does one memory read, then the write-back; an
//   any-identifier allocate checks one used bit per cycle through the single
//   memory read port.
// reset: after rst_ni rises a clearing pass writes every used bit to zero,
//   with busy high; no command is taken meanwhile.
// stalls: the receiver cannot hold results off; busy is the only back-pressure.
//
module next_fit_id_allocator_core
  import nfa_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   cmd_i,
  input  logic [IdentWidth-1:0]  ident_i,
  output logic                   done_o,
  output logic [StatusWidth-1:0] status_o,
  output logic [GrantWidth-1:0]  granted_id_o,
  output logic [CountWidth-1:0]  in_use_count_o
);

  localparam int unsigned AW = (NumIds > 1) ? $clog2(NumIds) : 1;
  localparam int unsigned CW = $clog2(NumIds + 1);
  localparam logic [AW-1:0] LastAddr = AW'(NumIds - 1);
  localparam logic [CW-1:0] FullCount = CW'(NumIds);

  // controller states
  localparam logic [1:0] SClear  = 2'd0;
  localparam logic [1:0] SIdle   = 2'd1;
  localparam logic [1:0] SLookup = 2'd2;
  localparam logic [1:0] SScan   = 2'd3;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] a);
    next_slot = (a == LastAddr) ? '0 : a + 1'b1;
  endfunction

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] ptr_q, ptr_d;           // next-fit search pointer
  logic [CW-1:0] count_q, count_d;       // identifiers in use
  logic [AW-1:0] clr_q, clr_d;           // clearing pass address
  logic          cmd_q, cmd_d;
  logic [AW-1:0] addr_q, addr_d;         // address whose read data is pending
  logic [AW-1:0] scan_q, scan_d;         // next address to read in a scan
  logic [AW-1:0] checked_q, checked_d;   // entries checked so far in a scan

  logic                   done_q, done_d;
  logic [StatusWidth-1:0] status_q, status_d;
  logic [GrantWidth-1:0]  grant_q, grant_d;
  logic [CountWidth-1:0]  out_cnt_q;

  // memory port
  logic          we, wdata, re, rdata;
  logic [AW-1:0] waddr, raddr;

  logic ident_valid;

  assign ident_valid = ({25'b0, ident_i} < 32'(NumIds));

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    count_d   = count_q;
    clr_d     = clr_q;
    cmd_d     = cmd_q;
    addr_d    = addr_q;
    scan_d    = scan_q;
    checked_d = checked_q;
    done_d    = 1'b0;
    status_d  = status_q;
    grant_d   = grant_q;
    we        = 1'b0;
    waddr     = addr_q;
    wdata     = 1'b0;
    re        = 1'b0;
    raddr     = AW'(ident_i);
    busy      = 1'b1;

    unique case (state_q)
      SClear: begin
        // sweep every used bit to free
        we    = 1'b1;
        waddr = clr_q;
        wdata = 1'b0;
        clr_d = clr_q + 1'b1;
        if (clr_q == LastAddr) begin
          state_d = SIdle;
        end
      end

      SIdle: begin
        // busy is low here, so start alone marks a transfer
        busy = 1'b0;
        if (start) begin
          cmd_d  = cmd_i;
          addr_d = AW'(ident_i);
          if (cmd_i == CMD_FREE) begin
            if (!ident_valid) begin
              done_d   = 1'b1;
              status_d = STATUS_INVALID;
              grant_d  = '0;
            end else begin
              re      = 1'b1;
              state_d = SLookup;
            end
          end else if (count_q >= FullCount) begin
            // full wins even over a named request
            done_d   = 1'b1;
            status_d = STATUS_FULL;
            grant_d  = '0;
          end else if (ident_valid) begin
            re      = 1'b1;
            state_d = SLookup;
          end else begin
            // any identifier: start the next-fit scan at the pointer
            re        = 1'b1;
            raddr     = ptr_q;
            addr_d    = ptr_q;
            scan_d    = next_slot(ptr_q);
            checked_d = '0;
            state_d   = SScan;
          end
        end
      end

      SLookup: begin
        done_d  = 1'b1;
        grant_d = '0;
        state_d = SIdle;
        if (cmd_q == CMD_FREE) begin
          if (!rdata) begin
            status_d = STATUS_ALREADY_FREE;
          end else begin
            we       = 1'b1;
            wdata    = 1'b0;
            status_d = STATUS_OK;
            if (count_q != '0) begin
              count_d = count_q - 1'b1;
            end
          end
        end else begin
          if (rdata) begin
            status_d = STATUS_TAKEN;
          end else begin
            we       = 1'b1;
            wdata    = 1'b1;
            count_d  = count_q + 1'b1;
            status_d = STATUS_OK;
            grant_d  = GrantWidth'(addr_q);
          end
        end
      end

      SScan: begin
        // rdata belongs to addr_q; the read of scan_q goes out meanwhile
        re    = 1'b1;
        raddr = scan_q;
        if (!rdata) begin
          we       = 1'b1;
          wdata    = 1'b1;
          count_d  = count_q + 1'b1;
          ptr_d    = next_slot(addr_q);
          done_d   = 1'b1;
          status_d = STATUS_OK;
          grant_d  = GrantWidth'(addr_q);
          state_d  = SIdle;
        end else if (checked_q == LastAddr) begin
          // whole table seen without a free bit, pointer stays put
          done_d   = 1'b1;
          status_d = STATUS_FULL;
          grant_d  = '0;
          state_d  = SIdle;
        end else begin
          addr_d    = scan_q;
          scan_d    = next_slot(scan_q);
          checked_d = checked_q + 1'b1;
        end
      end

      default: begin
        state_d = SClear;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      ptr_q   <= '0;
      count_q <= '0;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      count_q <= count_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    addr_q    <= addr_d;
    scan_q    <= scan_d;
    checked_q <= checked_d;
    status_q  <= status_d;
    grant_q   <= grant_d;
    if (done_d) begin
      out_cnt_q <= CountWidth'(count_d);
    end
  end

  nfa_used_ram #(
    .Depth (NumIds),
    .AddrW (AW)
  ) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign granted_id_o   = grant_q;
  assign in_use_count_o = out_cnt_q;

endmodule
